// ===== design/assert_macros.svh =====
// Assertion macros for the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== design/ips_pkg.sv =====
`default_nettype none

package ips_pkg;

  // Operating modes as they appear on the mode output.
  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_MONITOR = 3'd1;
  localparam logic [2:0] MODE_WATER   = 3'd2;
  localparam logic [2:0] MODE_PAUSE   = 3'd3;
  localparam logic [2:0] MODE_LOW     = 3'd4;
  localparam logic [2:0] MODE_CRIT    = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_DAY_SECONDS   = 3'd0;
  localparam logic [2:0] REG_NIGHT_SECONDS = 3'd1;
  localparam logic [2:0] REG_LOW_PERCENT   = 3'd2;
  localparam logic [2:0] REG_CRIT_PERCENT  = 3'd3;
  localparam logic [2:0] REG_SECOND_TICKS  = 3'd4;

  // Configuration reset values.
  localparam logic [7:0] DAY_SECONDS_RST   = 8'd30;
  localparam logic [7:0] NIGHT_SECONDS_RST = 8'd15;
  localparam logic [6:0] LOW_PERCENT_RST   = 7'd20;
  localparam logic [6:0] CRIT_PERCENT_RST  = 7'd10;
  localparam logic [9:0] SECOND_TICKS_RST  = 10'd10;

  // Full scale of the level converter is 4095 = 2^12 - 1.
  localparam int unsigned LEVEL_SHIFT = 12;
  localparam logic [6:0]  PCT_SCALE   = 7'd100;
  // Pressure per percent: 3 * 98 pascal.
  localparam logic [14:0] PA_PER_PCT  = 15'd294;

  typedef struct packed {
    logic [7:0] day_seconds;
    logic [7:0] night_seconds;
    logic [6:0] low_percent;
    logic [6:0] critical_percent;
    logic [9:0] second_ticks;
  } ips_cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        pump_on;
    logic        alert_on;
    logic [7:0]  seconds_left;
    logic [6:0]  level_percent;
    logic [14:0] pressure_pa;
    logic        low_level_note;
  } ips_result_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       pump;
    logic       alert;
    logic [6:0] level;
    logic [7:0] remaining;
    logic [7:0] paused;
    logic [7:0] saved;
  } ips_state_t;

endpackage

`default_nettype wire

// ===== design/ips_cfg.sv =====
`default_nettype none

module ips_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [9:0]     cfg_data,
  output ips_pkg::ips_cfg_t   cfg
);
  import ips_pkg::*;

  ips_cfg_t regs;

  // Writes must only arrive while the sequencer is idle (left to the user); all are taken.
  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.day_seconds      <= DAY_SECONDS_RST;
      regs.night_seconds    <= NIGHT_SECONDS_RST;
      regs.low_percent      <= LOW_PERCENT_RST;
      regs.critical_percent <= CRIT_PERCENT_RST;
      regs.second_ticks     <= SECOND_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DAY_SECONDS:   regs.day_seconds      <= cfg_data[7:0];
        REG_NIGHT_SECONDS: regs.night_seconds    <= cfg_data[7:0];
        REG_LOW_PERCENT:   regs.low_percent      <= cfg_data[6:0];
        REG_CRIT_PERCENT:  regs.critical_percent <= cfg_data[6:0];
        REG_SECOND_TICKS:  regs.second_ticks     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ips_level.sv =====
`default_nettype none

module ips_level (
  input  wire logic [11:0] level_sample,
  output logic [6:0]       percent
);
  import ips_pkg::*;

  logic [18:0] scaled;
  logic [18:0] corrected;

  // x / (2^12 - 1) equals (x + (x >> 12) + 1) >> 12 while the quotient stays
  // small, which holds here since it never exceeds 100.
  assign scaled    = 19'(level_sample) * 19'(PCT_SCALE);
  assign corrected = scaled + (scaled >> LEVEL_SHIFT) + 19'd1;
  assign percent   = corrected[LEVEL_SHIFT +: 7];

endmodule

`default_nettype wire

// ===== design/ips_core.sv =====
`default_nettype none

module ips_core #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic            soil_wet,
  input  wire logic            presence,
  input  wire logic            daylight,
  input  wire logic [6:0]      new_percent,
  input  ips_pkg::ips_cfg_t    cfg,
  output ips_pkg::ips_result_t result
);
  import ips_pkg::*;

  ips_state_t st;
  ips_state_t st_next;
  logic                  delay_running;
  logic                  delay_running_next;
  logic [TICK_WIDTH-1:0] tick_now;
  logic [TICK_WIDTH-1:0] delay_start;
  logic [TICK_WIDTH-1:0] delay_start_next;
  logic [TICK_WIDTH-1:0] elapsed;
  logic [TICK_WIDTH-1:0] ticks_wide;
  logic                  note;
  logic                  fire;

  // Level update plus the dry-soil and threshold checks of the monitor pass.
  function automatic ips_state_t monitor_pass(input ips_state_t s_in);
    ips_state_t s;
    s       = s_in;
    s.level = new_percent;
    if (s.mode != MODE_WATER) begin
      if (!soil_wet) begin
        s.mode      = MODE_WATER;
        s.remaining = daylight ? cfg.day_seconds : cfg.night_seconds;
        s.paused    = 8'd0;
        s.saved     = 8'd0;
        s.pump      = 1'b1;
      end else if (s.level <= cfg.low_percent && s.level > cfg.critical_percent) begin
        s.mode = MODE_LOW;
      end else if (s.level <= cfg.critical_percent) begin
        s.mode = MODE_CRIT;
      end
    end
    return s;
  endfunction

  assign elapsed    = tick_now - delay_start;
  assign ticks_wide = TICK_WIDTH'(cfg.second_ticks);

  always_comb begin
    st_next            = st;
    note               = 1'b0;
    fire               = 1'b0;
    delay_running_next = delay_running;
    delay_start_next   = delay_start;
    case (st.mode)
      MODE_MONITOR: begin
        st_next = monitor_pass(st);
      end
      MODE_WATER: begin
        if (presence) begin
          st_next.mode   = MODE_PAUSE;
          st_next.paused = st.remaining;
        end else if (st.level <= cfg.critical_percent) begin
          st_next.mode  = MODE_CRIT;
          st_next.saved = st.remaining;
        end else begin
          note = (st.level <= cfg.low_percent);
          if (!delay_running) begin
            delay_start_next   = tick_now;
            delay_running_next = 1'b1;
          end else if (elapsed >= ticks_wide) begin
            delay_running_next = 1'b0;
            fire               = 1'b1;
          end
          if (fire) begin
            if (st.remaining != 8'd0) begin
              st_next.remaining = st.remaining - 8'd1;
            end else begin
              st_next.pump = 1'b0;
              st_next.mode = MODE_MONITOR;
            end
          end
          st_next = monitor_pass(st_next);
        end
      end
      MODE_PAUSE: begin
        st_next.pump = 1'b0;
        if (!presence) begin
          st_next.mode      = MODE_WATER;
          st_next.remaining = st.paused;
          st_next.pump      = 1'b1;
        end
        st_next = monitor_pass(st_next);
      end
      MODE_LOW: begin
        st_next.alert = 1'b1;
        st_next       = monitor_pass(st_next);
        if (st_next.level > cfg.low_percent) begin
          st_next.mode = MODE_WATER;
        end else if (st_next.level <= cfg.critical_percent) begin
          st_next.saved = st_next.remaining;
          st_next.mode  = MODE_CRIT;
        end
      end
      MODE_CRIT: begin
        st_next.pump  = 1'b0;
        st_next.alert = 1'b1;
        st_next       = monitor_pass(st_next);
        if (st_next.level > cfg.critical_percent) begin
          st_next.alert     = 1'b0;
          st_next.mode      = MODE_WATER;
          st_next.remaining = st_next.saved;
          st_next.pump      = 1'b1;
        end
      end
      default: begin
        st_next.mode = MODE_MONITOR;
      end
    endcase
  end

  always_comb begin
    result.mode           = st_next.mode;
    result.pump_on        = st_next.pump;
    result.alert_on       = st_next.alert;
    result.seconds_left   = st_next.remaining;
    result.level_percent  = st_next.level;
    result.pressure_pa    = 15'(st_next.level) * PA_PER_PCT;
    result.low_level_note = note;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= '0;
      delay_running <= 1'b0;
      delay_start   <= '0;
      tick_now      <= '0;
    end else if (step) begin
      st            <= st_next;
      delay_running <= delay_running_next;
      delay_start   <= delay_start_next;
      tick_now      <= tick_now + TICK_WIDTH'(1);
    end
  end

endmodule

`default_nettype wire

// ===== design/irrigation_pump_sequencer.sv =====
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------------
// in       | input     | in_valid / in_stall   | soil_wet, presence, daylight,
//          |           |                      | level_sample
// out      | output    | out_valid / out_stall | mode, pump_on, alert_on, seconds_left,
//          |           |                      | level_percent, pressure_pa,
//          |           |                      | low_level_note
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An accepted item waits in the input register; its result then goes into the result register,
// ready to be taken. One item is accepted per cycle while in_stall is low.
// Reset (rst, synchronous) returns the sequencer to start mode with the pump
// off and the configuration registers at their defaults.
// in_stall rises only while an item sits in the input register and the result
// register is held by out_stall; the input is taken again once out moves.
`default_nettype none

`include "assert_macros.svh"

module irrigation_pump_sequencer #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items: one control tick each.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        soil_wet,
  input  wire logic        presence,
  input  wire logic        daylight,
  input  wire logic [11:0] level_sample,
  // Result items: one per control tick.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       mode,
  output logic             pump_on,
  output logic             alert_on,
  output logic [7:0]       seconds_left,
  output logic [6:0]       level_percent,
  output logic [14:0]      pressure_pa,
  output logic             low_level_note,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  import ips_pkg::*;

  ips_cfg_t    cfg;
  ips_result_t result_next;
  ips_result_t result;

  // Input register holding the accepted item.
  logic        hold_valid;
  logic        hold_wet;
  logic        hold_presence;
  logic        hold_daylight;
  logic [11:0] hold_sample;
  logic [6:0]  hold_percent;

  logic in_take;
  logic advance;

  // The held item moves into the result register whenever that register is
  // empty or its contents are being taken this cycle. The sequencer state is
  // updated in the same cycle, so state and results stay in item order.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  ips_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ips_level u_level (
    .level_sample (hold_sample),
    .percent      (hold_percent)
  );

  ips_core #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .soil_wet    (hold_wet),
    .presence    (hold_presence),
    .daylight    (hold_daylight),
    .new_percent (hold_percent),
    .cfg         (cfg),
    .result      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_wet      <= soil_wet;
      hold_presence <= presence;
      hold_daylight <= daylight;
      hold_sample   <= level_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign mode           = result.mode;
  assign pump_on        = result.pump_on;
  assign alert_on       = result.alert_on;
  assign seconds_left   = result.seconds_left;
  assign level_percent  = result.level_percent;
  assign pressure_pa    = result.pressure_pa;
  assign low_level_note = result.low_level_note;

  // The input side is only held back by a blocked result register.
  `ASSERT_ALWAYS(a_stall_cause, clk, rst, in_stall |-> (out_valid && out_stall))
  // The percent conversion never goes past full scale.
  `ASSERT_NEVER(a_percent_range, clk, rst, out_valid && (level_percent > PCT_SCALE))
  // Start mode is left on the first tick, so no result ever reports it.
  `ASSERT_NEVER(a_no_start_result, clk, rst, out_valid && (mode == MODE_START))
  // The result register shows a valid result in the cycle after its item leaves the input register.
  `ASSERT_ALWAYS(a_advance_loads, clk, rst, advance |=> out_valid)

endmodule

`default_nettype wire

// ===== tb/sv/pump_sequencer_checker.sv =====
module pump_sequencer_checker
  import ips_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        soil_wet,
  input  logic        presence,
  input  logic        daylight,
  input  logic [11:0] level_sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  mode,
  input  logic        pump_on,
  input  logic        alert_on,
  input  logic [7:0]  seconds_left,
  input  logic [6:0]  level_percent,
  input  logic [14:0] pressure_pa,
  input  logic        low_level_note,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output int          faults,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [14:0] PASCAL_PER_PERCENT = 15'd294;

  ips_cfg_t settings;

  // Shadow copy of the sequencer state.
  logic [2:0]            cur_mode;
  logic                  cur_pump;
  logic                  cur_alert;
  logic [6:0]            cur_level;
  logic [7:0]            cur_remain;
  logic [7:0]            cur_paused;
  logic [7:0]            cur_saved;
  logic                  timing;
  logic [TICK_WIDTH-1:0] tick_count;
  logic [TICK_WIDTH-1:0] timing_mark;

  ips_result_t expected_reports[$];

  function automatic logic [6:0] tank_percent(input logic [11:0] sample);
    int unsigned scaled;
    scaled = 32'(sample);
    scaled = scaled * 100 / 4095;
    return scaled[6:0];
  endfunction

  // The one-second delay: the first read arms it, a later read fires once
  // enough ticks have gone by.
  function automatic logic second_elapsed();
    logic [TICK_WIDTH-1:0] span;
    span = tick_count - timing_mark;
    if (!timing) begin
      timing_mark = tick_count;
      timing = 1'b1;
      return 1'b0;
    end
    if (span >= TICK_WIDTH'(settings.second_ticks)) begin
      timing = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic survey_tank(input logic wet, input logic day, input logic [11:0] sample);
    cur_level = tank_percent(sample);
    if (cur_mode != MODE_WATER) begin
      if (!wet) begin
        cur_mode   = MODE_WATER;
        cur_remain = day ? settings.day_seconds : settings.night_seconds;
        cur_paused = '0;
        cur_saved  = '0;
        cur_pump   = 1'b1;
      end else if (cur_level <= settings.low_percent &&
                   cur_level > settings.critical_percent) begin
        cur_mode = MODE_LOW;
      end else if (cur_level <= settings.critical_percent) begin
        cur_mode = MODE_CRIT;
      end
    end
  endtask

  task automatic advance_tick(input logic wet, input logic person, input logic day,
                              input logic [11:0] sample, output ips_result_t report);
    logic note;
    note = 1'b0;
    case (cur_mode)
      MODE_MONITOR: survey_tank(wet, day, sample);
      MODE_WATER: begin
        if (person) begin
          cur_mode   = MODE_PAUSE;
          cur_paused = cur_remain;
        end else if (cur_level <= settings.critical_percent) begin
          cur_mode  = MODE_CRIT;
          cur_saved = cur_remain;
        end else begin
          if (cur_level <= settings.low_percent) note = 1'b1;
          if (second_elapsed()) begin
            if (cur_remain != 8'd0) begin
              cur_remain = cur_remain - 8'd1;
            end else begin
              cur_pump = 1'b0;
              cur_mode = MODE_MONITOR;
            end
          end
          survey_tank(wet, day, sample);
        end
      end
      MODE_PAUSE: begin
        cur_pump = 1'b0;
        if (!person) begin
          cur_mode   = MODE_WATER;
          cur_remain = cur_paused;
          cur_pump   = 1'b1;
        end
        survey_tank(wet, day, sample);
      end
      MODE_LOW: begin
        cur_alert = 1'b1;
        survey_tank(wet, day, sample);
        if (cur_level > settings.low_percent) begin
          cur_mode = MODE_WATER;
        end else if (cur_level <= settings.critical_percent) begin
          cur_saved = cur_remain;
          cur_mode  = MODE_CRIT;
        end
      end
      MODE_CRIT: begin
        cur_pump  = 1'b0;
        cur_alert = 1'b1;
        survey_tank(wet, day, sample);
        if (cur_level > settings.critical_percent) begin
          cur_alert  = 1'b0;
          cur_mode   = MODE_WATER;
          cur_remain = cur_saved;
          cur_pump   = 1'b1;
        end
      end
      default: cur_mode = MODE_MONITOR;
    endcase
    tick_count = tick_count + TICK_WIDTH'(1);

    report.mode           = cur_mode;
    report.pump_on        = cur_pump;
    report.alert_on       = cur_alert;
    report.seconds_left   = cur_remain;
    report.level_percent  = cur_level;
    report.pressure_pa    = 15'(cur_level) * PASCAL_PER_PERCENT;
    report.low_level_note = note;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin : watch
    ips_result_t want;
    ips_result_t got;
    if (rst) begin
      settings    = {DAY_SECONDS_RST, NIGHT_SECONDS_RST, LOW_PERCENT_RST,
                     CRIT_PERCENT_RST, SECOND_TICKS_RST};
      cur_mode    = MODE_START;
      cur_pump    = 1'b0;
      cur_alert   = 1'b0;
      cur_level   = '0;
      cur_remain  = '0;
      cur_paused  = '0;
      cur_saved   = '0;
      timing      = 1'b0;
      tick_count  = '0;
      timing_mark = '0;
      faults      = 0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DAY_SECONDS:   settings.day_seconds      = cfg_data[7:0];
          REG_NIGHT_SECONDS: settings.night_seconds    = cfg_data[7:0];
          REG_LOW_PERCENT:   settings.low_percent      = cfg_data[6:0];
          REG_CRIT_PERCENT:  settings.critical_percent = cfg_data[6:0];
          REG_SECOND_TICKS:  settings.second_ticks     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_tick(soil_wet, presence, daylight, level_sample, want);
        expected_reports.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {mode, pump_on, alert_on, seconds_left, level_percent, pressure_pa,
               low_level_note};
        if (expected_reports.size() == 0) begin
          $error("result item arrived with none expected");
          faults++;
        end else begin
          want = expected_reports.pop_front();
          check_field("mode", want.mode, got.mode);
          check_field("pump_on", want.pump_on, got.pump_on);
          check_field("alert_on", want.alert_on, got.alert_on);
          check_field("seconds_left", want.seconds_left, got.seconds_left);
          check_field("level_percent", want.level_percent, got.level_percent);
          check_field("pressure_pa", want.pressure_pa, got.pressure_pa);
          check_field("low_level_note", want.low_level_note, got.low_level_note);
        end
      end
    end
    outstanding = expected_reports.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ips_pkg::*;

  // A stretch this long with no item moving on any channel means the block
  // is stuck. Legal gaps and stalls are much shorter than this.
  localparam int unsigned STUCK_LIMIT = 500;
  // Cycles to let pass after the last expected result, covering the
  // two-stage path through the block.
  localparam int unsigned SETTLE_CYCLES = 4;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        soil_wet;
  logic        presence;
  logic        daylight;
  logic [11:0] level_sample;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  mode;
  logic        pump_on;
  logic        alert_on;
  logic [7:0]  seconds_left;
  logic [6:0]  level_percent;
  logic [14:0] pressure_pa;
  logic        low_level_note;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [9:0]  cfg_data;

  int faults;
  int outstanding;

  // When set, neither side idles, so items move back to back.
  logic calm;

  irrigation_pump_sequencer uut (.*);
  pump_sequencer_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result side holds stall for a freshly drawn number of cycles after
  // each result item it takes. All changes happen at the falling edge.
  initial begin : result_side
    int unsigned hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) hold = calm ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if nothing is accepted on any channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Sends one tick item after an optional gap. It is entered at a falling
  // edge and returns at the falling edge after the item was accepted, with
  // valid still high so that a following item can go out without a dip.
  task automatic send_tick(input logic wet, input logic person, input logic day,
                           input logic [11:0] sample, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    soil_wet     <= wet;
    presence     <= person;
    daylight     <= day;
    level_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Ends a phase: stop sending, wait until every expected result has been
  // checked, then give the pipeline a few more cycles to go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(input logic [2:0] index, input logic [9:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes all five registers back to back. Only called while the block idles.
  task automatic apply_settings(input logic [7:0] day_secs, input logic [7:0] night_secs,
                                input logic [6:0] low_pct, input logic [6:0] crit_pct,
                                input logic [9:0] ticks);
    put_reg(REG_DAY_SECONDS, 10'(day_secs));
    put_reg(REG_NIGHT_SECONDS, 10'(night_secs));
    put_reg(REG_LOW_PERCENT, 10'(low_pct));
    put_reg(REG_CRIT_PERCENT, 10'(crit_pct));
    put_reg(REG_SECOND_TICKS, ticks);
    cfg_valid <= 1'b0;
  endtask

  // Walks the mode graph with the reset settings: low alert and its way back
  // to watering, pause and resume, critical entry from watering and the
  // recovery from it, the low-level note, and the level extremes.
  task automatic opening_run();
    send_tick(1, 0, 1, 12'd4095, $urandom_range(0, 11)); // start moves to monitor
    send_tick(1, 0, 1, 12'd2730, $urandom_range(0, 11));
    send_tick(1, 0, 0, 12'd600, $urandom_range(0, 11));  // level 14 gives low alert
    send_tick(1, 0, 0, 12'd600, $urandom_range(0, 11));
    send_tick(1, 0, 0, 12'd4095, $urandom_range(0, 11)); // level back up, water
    send_tick(1, 1, 1, 12'd4095, $urandom_range(0, 11)); // presence pauses
    send_tick(1, 1, 1, 12'd4095, $urandom_range(0, 11));
    send_tick(0, 0, 1, 12'd4095, $urandom_range(0, 11)); // person gone, resume
    send_tick(1, 0, 1, 12'd200, $urandom_range(0, 11));
    send_tick(1, 0, 1, 12'd200, $urandom_range(0, 11));  // stored level critical
    send_tick(1, 0, 1, 12'd1, $urandom_range(0, 11));
    send_tick(1, 0, 1, 12'd4095, $urandom_range(0, 11)); // critical recovers
    send_tick(0, 0, 1, 12'd0, $urandom_range(0, 11));
    send_tick(1, 0, 0, 12'd0, $urandom_range(0, 11));
    send_tick(1, 0, 0, 12'd600, $urandom_range(0, 11));
    send_tick(1, 0, 0, 12'd600, $urandom_range(0, 11));  // between thresholds: note
    send_tick(1, 0, 0, 12'd2048, $urandom_range(0, 11));
    send_tick(1, 0, 0, 12'd100, $urandom_range(0, 11));
    send_tick(1, 0, 0, 12'd100, $urandom_range(0, 11));
    send_tick(0, 0, 0, 12'd4095, $urandom_range(0, 11)); // dry soil while critical
    send_tick(1, 0, 1, 12'd4094, $urandom_range(0, 11));
    send_tick(0, 1, 0, 12'd4094, $urandom_range(0, 11));
    send_tick(0, 0, 0, 12'd3000, $urandom_range(0, 11));
  endtask

  // Random ticks in segments. Quiet segments keep people away and the tank
  // above the low threshold so that watering runs its countdown to the end;
  // busy segments mix in presence and levels near the thresholds.
  task automatic random_phase(input int unsigned count, input int unsigned low_pct);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned floor_sample;
    int unsigned near_sample;
    logic        quiet;
    logic        wet;
    logic        person;
    logic        day;
    logic [11:0] sample;
    floor_sample = ((low_pct + 1) * 4095 + 99) / 100;
    if (floor_sample > 4095) floor_sample = 4095;
    near_sample = (low_pct + 3) * 4095 / 100;
    if (near_sample > 4095) near_sample = 4095;
    sent = 0;
    while (sent < count) begin
      seg_len = $urandom_range(8, 40);
      if (seg_len > count - sent) seg_len = count - sent;
      quiet = ($urandom_range(0, 9) < 7);
      calm = ($urandom_range(0, 3) == 0);
      repeat (seg_len) begin
        wet = 1'($urandom_range(0, 1));
        day = 1'($urandom_range(0, 1));
        if (quiet) begin
          person = 1'b0;
          sample = 12'($urandom_range(floor_sample, 4095));
        end else begin
          person = ($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 1) == 1)
            sample = 12'($urandom_range(0, 4095));
          else
            sample = 12'($urandom_range(0, near_sample));
        end
        send_tick(wet, person, day, sample, calm ? 0 : $urandom_range(0, 11));
      end
      sent += seg_len;
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    logic [6:0] low_pct;
    rst          = 1'b1;
    calm         = 1'b0;
    in_valid     = 1'b0;
    soil_wet     = 1'b0;
    presence     = 1'b0;
    daylight     = 1'b0;
    level_sample = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DAY_SECONDS;
    cfg_data     = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // First phase runs on the reset settings.
    opening_run();
    random_phase(150, 32'(LOW_PERCENT_RST));
    drain();

    // Every register at its floor, the second length at one tick: zero-length watering ends almost at once.
    apply_settings(8'd0, 8'd0, 7'd0, 7'd0, 10'd1);
    random_phase(150, 0);
    drain();

    // Durations at their ceiling, thresholds at full scale: every level counts as critical.
    apply_settings(8'd255, 8'd255, 7'd100, 7'd100, 10'd1000);
    random_phase(100, 100);
    drain();

    // Critical threshold above the low one, so the low band is empty.
    apply_settings(8'd1, 8'd2, 7'd10, 7'd30, 10'd2);
    random_phase(60, 10);
    drain();

    // Short durations and short seconds so that countdowns finish often.
    repeat (6) begin
      low_pct = 7'($urandom_range(5, 60));
      apply_settings(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)), low_pct,
                     7'($urandom_range(0, low_pct)), 10'($urandom_range(1, 5)));
      random_phase(150, 32'(low_pct));
      drain();
    end

    if (faults == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ips_pkg.sv
design/ips_cfg.sv
design/ips_level.sv
design/ips_core.sv
design/irrigation_pump_sequencer.sv
tb/sv/pump_sequencer_checker.sv
tb/sv/tb.sv
